FILE: hdl/pic_pkg.sv
package pic_pkg;

  // Default sample and accumulator geometry.
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int ACC_FRAC_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Register indexes, at byte address 4*index.
  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_OUT_LOWER     = 3'd3,
    REG_OUT_UPPER     = 3'd4
  } reg_idx_t;

  // Input command codes.
  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_RECLAMP = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Register widths and reset values.
  localparam int GAIN_W   = 16;
  localparam int PERIOD_W = 24;
  localparam int LIMIT_W  = 16;
  localparam int DRIVE_W  = 16;

  localparam logic signed [LIMIT_W-1:0] OUT_LOWER_RST = 16'sh8000;
  localparam logic signed [LIMIT_W-1:0] OUT_UPPER_RST = 16'sh7FFF;

endpackage

FILE: hdl/pic_in_if.sv
interface pic_in_if
  import pic_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();

  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output mode, output setpoint, output measured,
                  input ready);
  modport sink   (input valid, input mode, input setpoint, input measured,
                  output ready);

endinterface

FILE: hdl/pic_out_if.sv
interface pic_out_if
  import pic_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic [DRIVE_W-1:0]        drive_frac;

  modport source (output valid, output drive, output drive_frac, input ready);
  modport sink   (input valid, input drive, input drive_frac, output ready);

endinterface

FILE: hdl/incremental_pi_controller.sv
// Incremental (velocity form) PI controller with output clamp. Each beat on the
// input channel carries a mode, a setpoint and a measurement; every beat gives
// exactly one result beat with the integer and fractional parts of the stored
// output. An update beat keeps the sequencer busy until the next beat
// can be accepted: one signed multiplier and one accumulator adder are shared
// over eight sequencer steps (error times integral gain, two partial products
// against the sample period, error difference times proportional gain,
// rounding, two additions and the clamp), and a final step loads the result
// register when free. Clear and unused beats skip to it, re-clamp to the clamp.
// A finished result waits in its output register while the sequencer goes
// back to accepting input. Gains, period and limits are written through the
// APB port and should only be changed while the block is idle.
module incremental_pi_controller
  import pic_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pic_in_if.sink                in_ch,
  pic_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int E_W    = SAMPLE_WIDTH + 1;
  localparam int DE_W   = SAMPLE_WIDTH + 2;
  localparam int MB_W   = PERIOD_W + 1;
  localparam int MA_W   = (DE_W > MB_W) ? DE_W : MB_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int OUT_W  = LIMIT_W + ACC_FRAC_BITS;
  localparam int ACC_W  = SAMPLE_WIDTH + 44;
  localparam int RND_SH = 32 - ACC_FRAC_BITS;
  localparam int PRP_SH = ACC_FRAC_BITS - 8;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KI,
    ST_LO,
    ST_HI,
    ST_KP,
    ST_RND,
    ST_PROP,
    ST_SUM,
    ST_CLAMP,
    ST_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [GAIN_W-1:0]  prop_gain_r;
  logic signed [GAIN_W-1:0]  integ_gain_r;
  logic [PERIOD_W-1:0]       period_r;
  logic signed [LIMIT_W-1:0] lower_r;
  logic signed [LIMIT_W-1:0] upper_r;

  // Controller state and datapath registers.
  logic signed [E_W-1:0]   prev_err_r;
  logic signed [OUT_W-1:0] prev_out_r;
  logic signed [E_W-1:0]   err_r;
  logic signed [E_W-1:0]   err_nxt;
  logic signed [DE_W-1:0]  derr_r;
  logic signed [MA_W-1:0]  p1hi_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [P_W-1:0]   prod_nxt;
  logic signed [ACC_W-1:0] acc_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic [DRIVE_W-1:0]        drive_frac_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] clamp_hi;
  logic signed [ACC_W-1:0] clamp_lo;
  logic signed [ACC_W-1:0] clamp_val;
  logic                    in_acc;
  logic                    out_free;

  // Register write and read on the APB port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      period_r     <= '0;
      lower_r      <= OUT_LOWER_RST;
      upper_r      <= OUT_UPPER_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_PROP_GAIN:     prop_gain_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:    integ_gain_r <= pwdata[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: period_r     <= pwdata[PERIOD_W-1:0];
        REG_OUT_LOWER:     lower_r      <= pwdata[LIMIT_W-1:0];
        REG_OUT_UPPER:     upper_r      <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PROP_GAIN:     prdata = {16'b0, prop_gain_r};
      REG_INTEG_GAIN:    prdata = {16'b0, integ_gain_r};
      REG_SAMPLE_PERIOD: prdata = {8'b0, period_r};
      REG_OUT_LOWER:     prdata = {16'b0, lower_r};
      REG_OUT_UPPER:     prdata = {16'b0, upper_r};
      default:           prdata = '0;
    endcase
  end

  // Handshakes.
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.drive      = drive_r;
  assign out_ch.drive_frac = drive_frac_r;

  // The error of the incoming sample, formed at one bit above the sample width.
  assign err_nxt = E_W'(in_ch.setpoint) - E_W'(in_ch.measured);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      ST_KI: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(integ_gain_r);
      end
      ST_LO: begin
        mul_a = MA_W'(prod_r[23:0]);
        mul_b = {1'b0, period_r};
      end
      ST_HI: begin
        mul_a = p1hi_r;
        mul_b = {1'b0, period_r};
      end
      ST_KP: begin
        mul_a = MA_W'(derr_r);
        mul_b = MB_W'(prop_gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Clamp against the scaled limits; the upper test comes first, so the upper
  // limit wins for a value above it and below the lower limit when they cross.
  always_comb begin
    clamp_hi = ACC_W'(upper_r) <<< ACC_FRAC_BITS;
    clamp_lo = ACC_W'(lower_r) <<< ACC_FRAC_BITS;
    if (acc_r > clamp_hi) begin
      clamp_val = clamp_hi;
    end else if (acc_r < clamp_lo) begin
      clamp_val = clamp_lo;
    end else begin
      clamp_val = acc_r;
    end
  end

  // Sequencer, datapath and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      prev_out_r  <= '0;
    end else begin
      // The emit step reloads the result register itself when it is taken.
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            err_r <= err_nxt;
            case (in_ch.mode)
              MODE_UPDATE: state_r <= ST_KI;
              MODE_CLEAR: begin
                prev_err_r <= '0;
                prev_out_r <= '0;
                state_r    <= ST_EMIT;
              end
              MODE_RECLAMP: begin
                acc_r   <= ACC_W'(prev_out_r);
                state_r <= ST_CLAMP;
              end
              default: state_r <= ST_EMIT;
            endcase
          end
        end
        // Error times integral gain; error difference for later.
        ST_KI: begin
          prod_r  <= prod_nxt;
          derr_r  <= DE_W'(err_r) - DE_W'(prev_err_r);
          state_r <= ST_LO;
        end
        // Low 24 bits of that product times the period; keep the high part.
        ST_LO: begin
          prod_r  <= prod_nxt;
          p1hi_r  <= prod_r[MA_W+23:24];
          state_r <= ST_HI;
        end
        // High part times the period.
        ST_HI: begin
          prod_r  <= prod_nxt;
          acc_r   <= ACC_W'(prod_r);
          state_r <= ST_KP;
        end
        // Proportional product; fold in the high partial product.
        ST_KP: begin
          prod_r  <= prod_nxt;
          acc_r   <= acc_r + (ACC_W'(prod_r) <<< 24);
          state_r <= ST_RND;
        end
        // Round the integral term to nearest, ties upwards.
        ST_RND: begin
          acc_r   <= (acc_r + RND_HALF) >>> RND_SH;
          state_r <= ST_PROP;
        end
        ST_PROP: begin
          acc_r   <= acc_r + (ACC_W'(prod_r) <<< PRP_SH);
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          acc_r      <= acc_r + ACC_W'(prev_out_r);
          prev_err_r <= err_r;
          state_r    <= ST_CLAMP;
        end
        ST_CLAMP: begin
          prev_out_r <= OUT_W'(clamp_val);
          state_r    <= ST_EMIT;
        end
        // Load the result register once it is free.
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            drive_r      <= prev_out_r[OUT_W-1:ACC_FRAC_BITS];
            drive_frac_r <= DRIVE_W'(prev_out_r[ACC_FRAC_BITS-1:0]);
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
